### rtl/pha_pkg.sv
// Shared constants and types for the pointer heading block.
// No dependencies; used by every module under rtl.
`timescale 1ns / 1ps
`default_nettype none

package pha_pkg;

	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int HEAD_BITS  = 16;

	// Sums of three coordinates need two more bits; magnitudes one less than that.
	localparam int DIFF_BITS = COORD_BITS + 2;
	localparam int MAG_BITS  = COORD_BITS + 1;

	localparam int ITERS    = ANGLE_BITS + 4;
	localparam int SCALE_SH = 60 - (COORD_BITS + 3);
	localparam int ACC_BITS = 32;

	// Rotation datapath: scaled magnitudes stay below 2^60 including CORDIC gain.
	localparam int CW = 62;
	// Angle accumulator in 2^-32 turns, signed, with headroom for the table sum.
	localparam int ZW = ACC_BITS + 2;

	localparam int EXT_BITS = (ANGLE_BITS > HEAD_BITS) ? ANGLE_BITS : HEAD_BITS;

	localparam int IN_BITS  = 6 * COORD_BITS;
	localparam int IN_BYTES = (IN_BITS + 7) / 8;
	localparam int OUT_BYTES = (HEAD_BITS + 7) / 8;

	localparam logic [ANGLE_BITS-1:0] HALF_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
	localparam logic [HEAD_BITS-1:0]  HALF_HEAD = HEAD_BITS'(EXT_BITS'(HALF_TURN));

	// atan(2^-i) in 2^-32 turns, rounded to nearest.
	localparam logic [ACC_BITS-1:0] ATAN_TAB [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	// Quadrant and special-case flags that ride along with the rotation.
	typedef struct packed {
		logic zero_u;
		logic neg_u;
		logic zero_v;
		logic neg_v;
	} meta_t;

endpackage

`default_nettype wire

### rtl/pointer_heading_atan2.sv
// Heading from an object center to a camera-shifted pointer, as a 16-bit turn code.
// Pipeline: one difference stage, one CORDIC micro-rotation per stage, one fold and output
// register. Throughput: one beat per cycle unless the output stalls; every stage has its
// own valid bit and empty stages fill even while the output beat waits. Reset clears all
// valid bits asynchronously.
// Depends on pha_pkg, pha_front, pha_cordic and pha_fold.
`timescale 1ns / 1ps
`default_nettype none

module pointer_heading_atan2 (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// pointer_x, pointer_y, camera_x, camera_y, origin_x, origin_y
	input  wire logic [pha_pkg::IN_BYTES*8-1:0]      s_tdata,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// heading
	output logic [pha_pkg::OUT_BYTES*8-1:0]          m_tdata,
	// updated
	output logic                                     m_tuser
);

	localparam int CB = pha_pkg::COORD_BITS;

	logic                          front_valid, cordic_ready;
	logic [pha_pkg::MAG_BITS-1:0]  mag_u, mag_v;
	pha_pkg::meta_t                front_meta, cordic_meta;
	logic                          cordic_valid, fold_ready;
	logic signed [pha_pkg::ZW-1:0] angle;
	logic [pha_pkg::HEAD_BITS-1:0] heading;

	pha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pointer_x (s_tdata[0*CB +: CB]),
		.pointer_y (s_tdata[1*CB +: CB]),
		.camera_x  (s_tdata[2*CB +: CB]),
		.camera_y  (s_tdata[3*CB +: CB]),
		.origin_x  (s_tdata[4*CB +: CB]),
		.origin_y  (s_tdata[5*CB +: CB]),
		.out_valid (front_valid),
		.out_ready (cordic_ready),
		.mag_u     (mag_u),
		.mag_v     (mag_v),
		.meta      (front_meta)
	);

	pha_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (cordic_ready),
		.mag_u     (mag_u),
		.mag_v     (mag_v),
		.in_meta   (front_meta),
		.out_valid (cordic_valid),
		.out_ready (fold_ready),
		.angle     (angle),
		.out_meta  (cordic_meta)
	);

	pha_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cordic_valid),
		.in_ready  (fold_ready),
		.angle     (angle),
		.meta      (cordic_meta),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.heading   (heading),
		.updated   (m_tuser)
	);

	assign m_tdata = (pha_pkg::OUT_BYTES*8)'(heading);

`ifndef SYNTHESIS
	// With the output free to move, the whole pipeline must be able to advance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled although the output stage can drain");

	// A beat without a heading carries a zero heading.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("non-updated beat carries a nonzero heading");
`endif

endmodule

`default_nettype wire

### rtl/pha_front.sv
// Input stage: forms the world-space differences, their magnitudes and quadrant flags.
// Depends on pha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pha_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] pointer_x,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] pointer_y,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] camera_x,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] camera_y,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] origin_x,
	input  wire logic signed [pha_pkg::COORD_BITS-1:0] origin_y,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [pha_pkg::MAG_BITS-1:0]          mag_u,
	output logic [pha_pkg::MAG_BITS-1:0]          mag_v,
	output pha_pkg::meta_t                        meta
);

	logic signed [pha_pkg::DIFF_BITS-1:0] u, v, abs_u, abs_v;
	logic                                 valid_s1;
	logic [pha_pkg::MAG_BITS-1:0]         mag_u_s1, mag_v_s1;
	pha_pkg::meta_t                       meta_s1;

	// u points right, v points up (screen y grows downward).
	assign u = pha_pkg::DIFF_BITS'(pointer_x) + pha_pkg::DIFF_BITS'(camera_x)
		- pha_pkg::DIFF_BITS'(origin_x);
	assign v = pha_pkg::DIFF_BITS'(origin_y)
		- (pha_pkg::DIFF_BITS'(pointer_y) + pha_pkg::DIFF_BITS'(camera_y));
	assign abs_u = u[pha_pkg::DIFF_BITS-1] ? -u : u;
	assign abs_v = v[pha_pkg::DIFF_BITS-1] ? -v : v;

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mag_u_s1       <= abs_u[pha_pkg::MAG_BITS-1:0];
			mag_v_s1       <= abs_v[pha_pkg::MAG_BITS-1:0];
			meta_s1.zero_u <= (u == '0);
			meta_s1.neg_u  <= u[pha_pkg::DIFF_BITS-1];
			meta_s1.zero_v <= (v == '0);
			meta_s1.neg_v  <= v[pha_pkg::DIFF_BITS-1];
		end
	end

	assign out_valid = valid_s1;
	assign mag_u     = mag_u_s1;
	assign mag_v     = mag_v_s1;
	assign meta      = meta_s1;

endmodule

`default_nettype wire

### rtl/pha_cordic.sv
// Vectoring CORDIC, one micro-rotation per pipeline stage, ITERS stages deep.
// Depends on pha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pha_cordic (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [pha_pkg::MAG_BITS-1:0] mag_u,
	input  wire logic [pha_pkg::MAG_BITS-1:0] mag_v,
	input  wire pha_pkg::meta_t               in_meta,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [pha_pkg::ZW-1:0]     angle,
	output pha_pkg::meta_t                    out_meta
);

	localparam int N = pha_pkg::ITERS;

	logic signed [pha_pkg::CW-1:0] x_s [N];
	logic signed [pha_pkg::CW-1:0] y_s [N];
	logic signed [pha_pkg::ZW-1:0] z_s [N];
	pha_pkg::meta_t                meta_s [N];
	logic [N-1:0]                  valid_s;
	logic [N:0]                    stage_ready;

	logic signed [pha_pkg::CW-1:0] x_in [N];
	logic signed [pha_pkg::CW-1:0] y_in [N];
	logic signed [pha_pkg::ZW-1:0] z_in [N];
	pha_pkg::meta_t                meta_in [N];
	logic [N-1:0]                  valid_in;

	assign stage_ready[N] = out_ready;
	assign in_ready       = stage_ready[0];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic signed [pha_pkg::CW-1:0] xs, ys;
		logic signed [pha_pkg::ZW-1:0] step;

		if (k == 0) begin : g_first
			assign x_in[k]     = pha_pkg::CW'(mag_u) << pha_pkg::SCALE_SH;
			assign y_in[k]     = pha_pkg::CW'(mag_v) << pha_pkg::SCALE_SH;
			assign z_in[k]     = '0;
			assign meta_in[k]  = in_meta;
			assign valid_in[k] = in_valid;
		end else begin : g_rest
			assign x_in[k]     = x_s[k-1];
			assign y_in[k]     = y_s[k-1];
			assign z_in[k]     = z_s[k-1];
			assign meta_in[k]  = meta_s[k-1];
			assign valid_in[k] = valid_s[k-1];
		end

		// Arithmetic shifts floor, matching the rotation's rounding.
		assign xs   = x_in[k] >>> k;
		assign ys   = y_in[k] >>> k;
		assign step = pha_pkg::ZW'(pha_pkg::ATAN_TAB[k]);

		assign stage_ready[k] = !valid_s[k] || stage_ready[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (stage_ready[k]) begin
				valid_s[k] <= valid_in[k];
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[k] && valid_in[k]) begin
				meta_s[k] <= meta_in[k];
				if (!y_in[k][pha_pkg::CW-1]) begin
					x_s[k] <= x_in[k] + ys;
					y_s[k] <= y_in[k] - xs;
					z_s[k] <= z_in[k] + step;
				end else begin
					x_s[k] <= x_in[k] - ys;
					y_s[k] <= y_in[k] + xs;
					z_s[k] <= z_in[k] - step;
				end
			end
		end
	end

	assign out_valid = valid_s[N-1];
	assign angle     = z_s[N-1];
	assign out_meta  = meta_s[N-1];

endmodule

`default_nettype wire

### rtl/pha_fold.sv
// Output stage: clamps and rounds the first-quadrant angle, folds it into the
// full turn and holds the result beat. Depends on pha_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pha_fold (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [pha_pkg::ZW-1:0] angle,
	input  wire pha_pkg::meta_t                meta,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [pha_pkg::HEAD_BITS-1:0]      heading,
	output logic                               updated
);

	localparam logic signed [pha_pkg::ZW-1:0] QUARTER =
		pha_pkg::ZW'(1) <<< (pha_pkg::ACC_BITS - 2);
	localparam logic [pha_pkg::ACC_BITS-2:0] ROUND_HALF =
		(pha_pkg::ACC_BITS - 1)'(1) << (pha_pkg::ACC_BITS - pha_pkg::ANGLE_BITS - 1);

	logic signed [pha_pkg::ZW-1:0]   clamped;
	logic [pha_pkg::ACC_BITS-2:0]    rounded;
	logic [pha_pkg::ANGLE_BITS-1:0]  t, h;
	logic [pha_pkg::EXT_BITS-1:0]    h_ext;
	logic                            valid_q;
	logic [pha_pkg::HEAD_BITS-1:0]   heading_q;
	logic                            updated_q;

	always_comb begin
		if (angle[pha_pkg::ZW-1]) begin
			clamped = '0;
		end else if (angle > QUARTER) begin
			clamped = QUARTER;
		end else begin
			clamped = angle;
		end
	end

	// The clamp keeps the value below 2^(ACC_BITS-1), so the rounding add cannot carry out.
	assign rounded = clamped[pha_pkg::ACC_BITS-2:0] + ROUND_HALF;

	always_comb begin
		if (meta.zero_v) begin
			t = '0;
		end else begin
			t = pha_pkg::ANGLE_BITS'(rounded[pha_pkg::ACC_BITS-2:pha_pkg::ACC_BITS-pha_pkg::ANGLE_BITS]);
		end
		// The mod-one-turn wrap falls out of the fixed width.
		if (!meta.neg_u && !meta.neg_v) begin
			h = t;
		end else if (meta.neg_u && !meta.neg_v) begin
			h = pha_pkg::HALF_TURN - t;
		end else if (meta.neg_u) begin
			h = pha_pkg::HALF_TURN + t;
		end else begin
			h = -t;
		end
	end

	assign h_ext    = pha_pkg::EXT_BITS'(h);
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			if (meta.zero_u) begin
				heading_q <= '0;
				updated_q <= 1'b0;
			end else begin
				heading_q <= h_ext[pha_pkg::HEAD_BITS-1:0];
				updated_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign heading   = heading_q;
	assign updated   = updated_q;

`ifndef SYNTHESIS
	// A purely horizontal vector must land on zero or a half turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && in_valid && !meta.zero_u && meta.zero_v)
		|=> (heading_q == '0 || heading_q == pha_pkg::HALF_HEAD))
		else $error("horizontal vector gave an off-axis heading");
`endif

endmodule

`default_nettype wire

### dv/tb_pointer_heading_atan2.sv
// Testbench for pointer_heading_atan2: directed table plus random coordinate sets, each beat
// checked against a typed heading or the CORDIC predictor. Depends on pha_pkg and the rtl sources.
`timescale 1ns / 1ps

module tb_pointer_heading_atan2;

	localparam int CLK_HALF         = 6;
	localparam int N_RANDOM         = 1380;
	localparam int QUIET_TAIL       = 150;
	localparam int LONG_HOLD_AT     = 300;
	localparam int LONG_HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES     = 40;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int CORDIC_STEPS     = 20;
	localparam int PRESCALE         = 41;

	// atan(2^-i) in 2^-32 turns.
	localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
	};

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] camx;
		logic signed [15:0] camy;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
	} coord_set_t;

	typedef struct packed {
		logic [15:0] heading;
		logic        updated;
	} heading_t;

	typedef struct packed {
		coord_set_t c;
		logic       typed;
		heading_t   want;
	} dir_row_t;

	localparam heading_t NO_HEADING = '{16'h0000, 1'b0};

	localparam dir_row_t DIR_ROWS [20] = '{
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NO_HEADING},
		'{'{16'sd100, 16'sd7, -16'sd100, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NO_HEADING},
		'{'{16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'h0000, 1'b1}},
		'{'{-16'sd5, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'h8000, 1'b1}},
		// Tiny downward angle at the widest horizontal reach wraps to zero.
		'{'{16'sh7FFF, 16'sd1, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sd0}, 1'b1, '{16'h0000, 1'b1}},
		'{'{16'sh8000, 16'sd1, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sd0}, 1'b1, '{16'h8000, 1'b1}},
		'{'{16'sd1, 16'sh8000, 16'sd0, 16'sh8000, 16'sd0, 16'sh7FFF}, 1'b0, NO_HEADING},
		'{'{-16'sd1, 16'sh7FFF, 16'sd0, 16'sh7FFF, 16'sd0, 16'sh8000}, 1'b0, NO_HEADING},
		'{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, NO_HEADING},
		'{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, NO_HEADING},
		'{'{16'sd10, -16'sd10, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_HEADING},
		'{'{-16'sd10, -16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_HEADING},
		'{'{-16'sd10, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_HEADING},
		'{'{16'sd10, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, NO_HEADING},
		'{'{16'sd0, -16'sd50, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, NO_HEADING},
		'{'{16'sd0, 16'sd0, -16'sd200, 16'sd300, 16'sd0, 16'sd0}, 1'b0, NO_HEADING},
		'{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000}, 1'b0, NO_HEADING},
		'{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'h0000, 1'b1}},
		'{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1}, 1'b1, NO_HEADING},
		'{'{16'sd1234, -16'sd4321, -16'sd567, 16'sd765, -16'sd2000, 16'sd3000}, 1'b0,
			NO_HEADING}
	};

	logic                                clk;
	logic                                arst_n;
	logic                                s_tvalid;
	logic                                s_tready;
	logic [pha_pkg::IN_BYTES*8-1:0]      s_tdata;
	logic                                m_tvalid;
	logic                                m_tready;
	logic [pha_pkg::OUT_BYTES*8-1:0]     m_tdata;
	logic                                m_tuser;

	heading_t expected_heads [$];
	heading_t seen_want;
	int       n_accepted;
	int       err_cnt;
	int       gap_pct;
	int       cycle_cnt;
	bit       quiet;

	pointer_heading_atan2 u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Vectoring CORDIC on the absolute differences, then the quadrant fold.
	function automatic heading_t heading_of(coord_set_t c);
		longint   u, v, a, b, x, y, z, xs, ys;
		logic [16:0] t, h;
		heading_t r;
		u = (longint'(c.px) + longint'(c.camx)) - longint'(c.cx);
		v = longint'(c.cy) - (longint'(c.py) + longint'(c.camy));
		r = NO_HEADING;
		if (u == 0)
			return r;
		a = (u < 0) ? -u : u;
		b = (v < 0) ? -v : v;
		t = '0;
		if (b != 0) begin
			x = a <<< PRESCALE;
			y = b <<< PRESCALE;
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(ATAN_TURN[i]);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(ATAN_TURN[i]);
				end
			end
			if (z < 0)
				z = 0;
			if (z > (longint'(1) <<< 30))
				z = longint'(1) <<< 30;
			t = 17'((z + 32768) >>> 16);
		end
		if (u > 0 && v >= 0)
			h = t;
		else if (u < 0 && v >= 0)
			h = 17'h08000 - t;
		else if (u < 0)
			h = 17'h08000 + t;
		else
			h = 17'h10000 - t;
		r.heading = h[15:0];
		r.updated = 1'b1;
		return r;
	endfunction

	function automatic logic [15:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Called just after a rising edge; returns just after the edge that took the beat.
	task automatic send_coords(coord_set_t c, heading_t want);
		if (!quiet && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {c.cy, c.cx, c.camy, c.camx, c.py, c.px};
		forever begin
			@(negedge clk);
			if (s_tready)
				break;
			@(posedge clk);
		end
		expected_heads.push_back(want);
		n_accepted++;
		@(posedge clk);
	endtask

	// Stimulus and end of run.
	initial begin
		coord_set_t c;
		int         mode, dx, dy, ax, ay, bx, by;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		quiet      = 1'b0;
		n_accepted = 0;
		err_cnt    = 0;
		gap_pct    = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < $size(DIR_ROWS); k++)
			send_coords(DIR_ROWS[k].c,
				DIR_ROWS[k].typed ? DIR_ROWS[k].want : heading_of(DIR_ROWS[k].c));

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k % 64 == 0) begin
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 12;
					default: gap_pct = 35;
				endcase
			end
			if (k >= N_RANDOM - QUIET_TAIL)
				quiet = 1'b1;
			c = coord_set_t'({$urandom, $urandom, $urandom});
			mode = $urandom_range(0, 9);
			ax = int'($urandom_range(0, 32000)) - 16000;
			ay = int'($urandom_range(0, 32000)) - 16000;
			bx = int'($urandom_range(0, 32000)) - 16000;
			by = int'($urandom_range(0, 32000)) - 16000;
			dx = int'($urandom_range(0, 600)) - 300;
			dy = int'($urandom_range(0, 600)) - 300;
			if (mode == 9) begin
				// Equal magnitudes land on the diagonals of each quadrant.
				dx = $urandom_range(1, 700);
				dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
				if ($urandom_range(0, 1) != 0)
					dx = -dx;
			end
			case (mode)
				4, 5, 9: begin
					c.cx   = 16'(ax);
					c.camx = 16'(bx);
					c.px   = 16'(ax + dx - bx);
					c.cy   = 16'(ay);
					c.camy = 16'(by);
					c.py   = 16'(ay - dy - by);
				end
				6: begin
					c.cx   = 16'(ax);
					c.camx = 16'(bx);
					c.px   = 16'(ax - bx);
				end
				7: begin
					c.cy   = 16'(ay);
					c.camy = 16'(by);
					c.py   = 16'(ay - by);
				end
				8: begin
					c.px   = pick_extreme();
					c.py   = pick_extreme();
					c.camx = pick_extreme();
					c.camy = pick_extreme();
					c.cx   = pick_extreme();
					c.cy   = pick_extreme();
				end
				default: ;
			endcase
			send_coords(c, heading_of(c));
		end
		s_tvalid <= 1'b0;

		while (expected_heads.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0 && expected_heads.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Output side: random stall bursts, and one long hold-off so the pipeline backs up.
	initial begin
		int stall_left, window, stall_pct;
		bit held_long;
		m_tready   = 1'b0;
		stall_left = 0;
		window     = 0;
		stall_pct  = 0;
		held_long  = 1'b0;
		forever begin
			@(posedge clk);
			if (window == 0) begin
				window = 64;
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 8;
					default: stall_pct = 30;
				endcase
			end
			window--;
			if (stall_left == 0 && !quiet) begin
				if (!held_long && n_accepted >= LONG_HOLD_AT) begin
					held_long  = 1'b1;
					stall_left = LONG_HOLD_CYCLES;
				end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
					stall_left = $urandom_range(1, 18);
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Sampled at the falling edge, where both sides of each handshake are settled.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_heads.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected beat, expected none, actual heading %h updated %b",
					$time, m_tdata, m_tuser);
			end else begin
				seen_want = expected_heads.pop_front();
				if (m_tdata != seen_want.heading) begin
					err_cnt++;
					$display("%0t: heading mismatch, expected %h actual %h",
						$time, seen_want.heading, m_tdata);
				end
				if (m_tuser != seen_want.updated) begin
					err_cnt++;
					$display("%0t: updated mismatch, expected %b actual %b",
						$time, seen_want.updated, m_tuser);
				end
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
rtl/pha_pkg.sv
rtl/pha_front.sv
rtl/pha_cordic.sv
rtl/pha_fold.sv
rtl/pointer_heading_atan2.sv
dv/tb_pointer_heading_atan2.sv
